// ----- rtl/core/igr_pkg.sv -----
// shared types, constants and register codes for the gravity removal core
`default_nettype none

package igr_pkg;

	// averaging window, kept a power of two so the divide is a shift (1 to 32)
	localparam int WIN_LOG2  = 3;
	localparam int WINDOW    = 1 << WIN_LOG2;
	localparam int WIN_DEPTH = WINDOW + 1;
	localparam int SLOT_W    = $clog2(WIN_DEPTH);
	localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

	// datapath widths
	localparam int RAW_W   = 16;
	localparam int SAMP_W  = 32;
	localparam int SUM_W   = SAMP_W + $clog2(WIN_DEPTH);
	localparam int OUT_W   = 48;
	localparam int PRD_W   = SUM_W + 17;
	localparam int SCL_W   = SUM_W + 18;

	// output rounding term and saturation bounds
	localparam int ROUND_OUT = WINDOW * 32768;
	localparam logic signed [SCL_W-1:0] OUT_HI = SCL_W'((longint'(1) <<< (OUT_W - 1)) - 1);
	localparam logic signed [SCL_W-1:0] OUT_LO = -OUT_HI - 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_SCALE,
		REG_GRAVITY,
		REG_PERIOD_SQ
	} cfg_reg_t;

	localparam logic [23:0] ACCEL_SCALE_RST = 24'd20084;
	localparam logic [30:0] GRAVITY_RST     = 31'd164528285;
	localparam logic [31:0] PERIOD_SQ_RST   = 32'd429497;

	typedef struct packed {
		logic [23:0] accel_scale;
		logic [30:0] gravity;
		logic [31:0] sample_period_sq;
	} cfg_t;

	// input transaction
	typedef struct packed {
		logic                    restart;
		logic signed [RAW_W-1:0] accel_x_raw;
		logic signed [RAW_W-1:0] accel_y_raw;
		logic signed [RAW_W-1:0] accel_z_raw;
		logic signed [RAW_W-1:0] quat_w;
		logic signed [RAW_W-1:0] quat_x;
		logic signed [RAW_W-1:0] quat_y;
		logic signed [RAW_W-1:0] quat_z;
	} sample_t;

	// output transaction
	typedef struct packed {
		logic signed [OUT_W-1:0] disp_x;
		logic signed [OUT_W-1:0] disp_y;
		logic signed [OUT_W-1:0] disp_z;
		logic                    last;
	} result_t;

	// compensated sample from the front pipeline
	typedef struct packed {
		logic                     done;
		logic signed [SAMP_W-1:0] c_x;
		logic signed [SAMP_W-1:0] c_y;
		logic signed [SAMP_W-1:0] c_z;
	} comp_out_t;

	// running window sums
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
	} sums_t;

	// scaled averages from the output pipeline
	typedef struct packed {
		logic                    done;
		logic signed [OUT_W-1:0] disp_x;
		logic signed [OUT_W-1:0] disp_y;
		logic signed [OUT_W-1:0] disp_z;
	} scale_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMP,
		ST_SCALE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/igr_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module igr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/igr_comp.sv -----
// five-stage pipeline: accel scaling and rotated gravity subtraction per axis
`default_nettype none

module igr_comp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  igr_pkg::sample_t   sample,
	input  igr_pkg::cfg_t      cfg,
	output igr_pkg::comp_out_t res
);
	import igr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [40:0] ax_s1, ay_s1, az_s1;
	logic signed [31:0] xz_s1, wy_s1, wx_s1, yz_s1;
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1;

	logic signed [33:0] gq_x_s2, gq_y_s2, gq_z_s2;
	logic signed [32:0] acc_x_s2, acc_y_s2, acc_z_s2;

	logic signed [49:0] hi_x_s3, hi_y_s3, hi_z_s3;
	logic signed [50:0] lo_x_s3, lo_y_s3, lo_z_s3;
	logic signed [32:0] acc_x_s3, acc_y_s3, acc_z_s3;

	logic signed [31:0] g_x_s4, g_y_s4, g_z_s4;
	logic signed [32:0] acc_x_s4, acc_y_s4, acc_z_s4;

	logic signed [SAMP_W-1:0] c_x_s5, c_y_s5, c_z_s5;

	logic signed [15:0] grav_hi;
	logic signed [16:0] grav_lo;
	logic signed [24:0] scale_s;

	function automatic logic signed [SAMP_W-1:0] sat_samp(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -34'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return $signed(v[SAMP_W-1:0]);
	endfunction

	assign scale_s = $signed({1'b0, cfg.accel_scale});
	assign grav_hi = $signed({1'b0, cfg.gravity[30:16]});
	assign grav_lo = $signed({1'b0, cfg.gravity[15:0]});

	// stage valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: raw times scale, quaternion cross products
	always_ff @(posedge clk) begin
		ax_s1 <= sample.accel_x_raw * scale_s;
		ay_s1 <= sample.accel_y_raw * scale_s;
		az_s1 <= sample.accel_z_raw * scale_s;
		xz_s1 <= sample.quat_x * sample.quat_z;
		wy_s1 <= sample.quat_w * sample.quat_y;
		wx_s1 <= sample.quat_w * sample.quat_x;
		yz_s1 <= sample.quat_y * sample.quat_z;
		ww_s1 <= sample.quat_w * sample.quat_w;
		xx_s1 <= sample.quat_x * sample.quat_x;
		yy_s1 <= sample.quat_y * sample.quat_y;
		zz_s1 <= sample.quat_z * sample.quat_z;
	end

	// stage 2: gravity direction in q.28, accel rounded to q.16
	always_ff @(posedge clk) begin
		gq_x_s2  <= (34'(xz_s1) - 34'(wy_s1)) <<< 1;
		gq_y_s2  <= (34'(wx_s1) + 34'(yz_s1)) <<< 1;
		gq_z_s2  <= 34'(ww_s1) - 34'(xx_s1) - 34'(yy_s1) + 34'(zz_s1);
		acc_x_s2 <= 33'((ax_s1 + 41'sd128) >>> 8);
		acc_y_s2 <= 33'((ay_s1 + 41'sd128) >>> 8);
		acc_z_s2 <= 33'((az_s1 + 41'sd128) >>> 8);
	end

	// stage 3: direction times gravity, split in high and low halves
	always_ff @(posedge clk) begin
		hi_x_s3  <= gq_x_s2 * grav_hi;
		hi_y_s3  <= gq_y_s2 * grav_hi;
		hi_z_s3  <= gq_z_s2 * grav_hi;
		lo_x_s3  <= gq_x_s2 * grav_lo;
		lo_y_s3  <= gq_y_s2 * grav_lo;
		lo_z_s3  <= gq_z_s2 * grav_lo;
		acc_x_s3 <= acc_x_s2;
		acc_y_s3 <= acc_y_s2;
		acc_z_s3 <= acc_z_s2;
	end

	// stage 4: merge halves and round gravity term to q.16
	always_ff @(posedge clk) begin
		g_x_s4   <= 32'((52'(hi_x_s3) + 52'(lo_x_s3 >>> 16) + 52'sd524288) >>> 20);
		g_y_s4   <= 32'((52'(hi_y_s3) + 52'(lo_y_s3 >>> 16) + 52'sd524288) >>> 20);
		g_z_s4   <= 32'((52'(hi_z_s3) + 52'(lo_z_s3 >>> 16) + 52'sd524288) >>> 20);
		acc_x_s4 <= acc_x_s3;
		acc_y_s4 <= acc_y_s3;
		acc_z_s4 <= acc_z_s3;
	end

	// stage 5: subtract and saturate
	always_ff @(posedge clk) begin
		c_x_s5 <= sat_samp(34'(acc_x_s4) - 34'(g_x_s4));
		c_y_s5 <= sat_samp(34'(acc_y_s4) - 34'(g_y_s4));
		c_z_s5 <= sat_samp(34'(acc_z_s4) - 34'(g_z_s4));
	end

	assign res.done = v_s5;
	assign res.c_x  = c_x_s5;
	assign res.c_y  = c_y_s5;
	assign res.c_z  = c_z_s5;

endmodule

`default_nettype wire

// ----- rtl/core/igr_scale.sv -----
// two-stage output scaling: sum times squared period, average and saturate
`default_nettype none

module igr_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  igr_pkg::sums_t      sums,
	input  logic [31:0]         period_sq,
	output igr_pkg::scale_out_t res
);
	import igr_pkg::*;

	logic v_s1, v_s2;
	logic signed [16:0] per_hi, per_lo;

	logic signed [PRD_W-1:0] hi_x_s1, hi_y_s1, hi_z_s1;
	logic signed [PRD_W-1:0] lo_x_s1, lo_y_s1, lo_z_s1;
	logic signed [SCL_W-1:0] t_x_s2, t_y_s2, t_z_s2;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SCL_W-1:0] v);
		if (v > OUT_HI) begin
			return $signed(OUT_HI[OUT_W-1:0]);
		end else if (v < OUT_LO) begin
			return $signed(OUT_LO[OUT_W-1:0]);
		end
		return $signed(v[OUT_W-1:0]);
	endfunction

	assign per_hi = $signed({1'b0, period_sq[31:16]});
	assign per_lo = $signed({1'b0, period_sq[15:0]});

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// stage 1: partial products against the period halves
	always_ff @(posedge clk) begin
		hi_x_s1 <= sums.sum_x * per_hi;
		hi_y_s1 <= sums.sum_y * per_hi;
		hi_z_s1 <= sums.sum_z * per_hi;
		lo_x_s1 <= sums.sum_x * per_lo;
		lo_y_s1 <= sums.sum_y * per_lo;
		lo_z_s1 <= sums.sum_z * per_lo;
	end

	// stage 2: merge with rounding, held for the whole burst
	always_ff @(posedge clk) begin
		if (v_s1) begin
			t_x_s2 <= SCL_W'(hi_x_s1) + ((SCL_W'(lo_x_s1) + SCL_W'(ROUND_OUT)) >>> 16);
			t_y_s2 <= SCL_W'(hi_y_s1) + ((SCL_W'(lo_y_s1) + SCL_W'(ROUND_OUT)) >>> 16);
			t_z_s2 <= SCL_W'(hi_z_s1) + ((SCL_W'(lo_z_s1) + SCL_W'(ROUND_OUT)) >>> 16);
		end
	end

	// floor divide by the window and clamp to the output range
	assign res.done   = v_s2;
	assign res.disp_x = sat_out(t_x_s2 >>> WIN_LOG2);
	assign res.disp_y = sat_out(t_y_s2 >>> WIN_LOG2);
	assign res.disp_z = sat_out(t_z_s2 >>> WIN_LOG2);

endmodule

`default_nettype wire

// ----- rtl/core/imu_gravity_removal_moving_average_core.sv -----
// top level: config registers, window memory, sequencer and output register
`default_nettype none

// Removes rotated gravity from each IMU sample and outputs the sum of the last
// WINDOW+1 compensated samples, divided by WINDOW and times the squared sample
// period. One sample is worked on at a time. A sample that produces no
// result frees the input once it has passed the 5-stage compensation pipeline
// and the window update, whose old entry is read from the window memory at
// acceptance. A sample with a result then goes through the 2-stage output
// scaler and the output register. The sample that first fills the window
// emits WINDOW+1 equal results, one per cycle as the output takes them; input
// is held off until the last of them sits in the output register. A result
// may wait in the output register while the next sample is accepted. The
// config port is always ready and should be written only while the core is
// idle.

module imu_gravity_removal_moving_average_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  igr_pkg::sample_t                 sample,
	output logic                             result_valid,
	input  logic                             result_ready,
	output igr_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [igr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [igr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import igr_pkg::*;

	state_t state_q, state_d;
	cfg_t   cfg_q;
	sums_t  sum_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] remain_q;
	logic              scale_go_q;
	logic              result_valid_q;
	result_t           result_q;

	logic sample_fire, upd, emit_load, full;
	logic [FILL_W-1:0] burst_n;

	comp_out_t  comp_res;
	scale_out_t scale_res;

	logic [SLOT_W-1:0]   rd_addr;
	logic [3*SAMP_W-1:0] rd_data;
	logic [3*SAMP_W-1:0] wr_data;
	logic signed [SAMP_W-1:0] old_x, old_y, old_z;

	assign cfg_ready   = 1'b1;
	assign sample_fire = sample_valid && sample_ready;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{accel_scale: ACCEL_SCALE_RST, gravity: GRAVITY_RST,
				sample_period_sq: PERIOD_SQ_RST};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACCEL_SCALE: cfg_q.accel_scale <= cfg_data[23:0];
				REG_GRAVITY: cfg_q.gravity <= cfg_data[30:0];
				REG_PERIOD_SQ: cfg_q.sample_period_sq <= cfg_data;
				default: ;
			endcase
		end
	end

	// compensation pipeline
	igr_comp u_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sample_fire),
		.sample (sample),
		.cfg    (cfg_q),
		.res    (comp_res)
	);

	// window memory, x/y/z packed in one word; old entry read at acceptance
	assign rd_addr = sample.restart ? '0 : slot_q;
	assign wr_data = {comp_res.c_x, comp_res.c_y, comp_res.c_z};

	igr_ram #(
		.WIDTH (3 * SAMP_W),
		.DEPTH (WIN_DEPTH)
	) u_win_ram (
		.clk     (clk),
		.wr_en   (upd),
		.wr_addr (slot_q),
		.wr_data (wr_data),
		.rd_en   (sample_fire),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign old_x = $signed(rd_data[3*SAMP_W-1 -: SAMP_W]);
	assign old_y = $signed(rd_data[2*SAMP_W-1 -: SAMP_W]);
	assign old_z = $signed(rd_data[SAMP_W-1:0]);

	// window fill and burst length
	assign full = (fill_q == FILL_W'(WIN_DEPTH));
	always_comb begin
		if (full) begin
			burst_n = FILL_W'(1);
		end else if (fill_q == FILL_W'(WIN_DEPTH - 1)) begin
			burst_n = FILL_W'(WIN_DEPTH);
		end else begin
			burst_n = '0;
		end
	end

	// sequencer next state
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		upd          = 1'b0;
		emit_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (comp_res.done) begin
					upd     = 1'b1;
					state_d = (burst_n == '0) ? ST_IDLE : ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scale_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!result_valid_q || result_ready) begin
					emit_load = 1'b1;
					if (remain_q == FILL_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window sums, fill count and write slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (sample_fire && sample.restart) begin
			sum_q  <= '0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (upd) begin
			sum_q.sum_x <= sum_q.sum_x + SUM_W'(comp_res.c_x) - (full ? SUM_W'(old_x) : SUM_W'(0));
			sum_q.sum_y <= sum_q.sum_y + SUM_W'(comp_res.c_y) - (full ? SUM_W'(old_y) : SUM_W'(0));
			sum_q.sum_z <= sum_q.sum_z + SUM_W'(comp_res.c_z) - (full ? SUM_W'(old_z) : SUM_W'(0));
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
			slot_q <= (slot_q == SLOT_W'(WIN_DEPTH - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// burst counter and scaler kick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q   <= '0;
			scale_go_q <= 1'b0;
		end else begin
			scale_go_q <= upd && (burst_n != '0);
			if (upd) begin
				remain_q <= burst_n;
			end else if (emit_load) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	// output scaling
	igr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scale_go_q),
		.sums      (sum_q),
		.period_sq (cfg_q.sample_period_sq),
		.res       (scale_res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.disp_x <= scale_res.disp_x;
			result_q.disp_y <= scale_res.disp_y;
			result_q.disp_z <= scale_res.disp_z;
			result_q.last   <= (remain_q == FILL_W'(1));
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- rtl/core/igr_checker.sv -----
// port-level checks for the gravity removal core, bound to the top level
`default_nettype none

module igr_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_ready,
	input logic             result_valid,
	input logic             result_ready,
	input igr_pkg::result_t result,
	input logic             cfg_valid,
	input logic             cfg_ready
);

	// one sample at a time: busy right after a transaction
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("input ready right after a sample transaction");

	// a burst continues with the next equal result at once
	a_burst_equal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last |=> result_valid
		&& result.disp_x == $past(result.disp_x)
		&& result.disp_y == $past(result.disp_y)
		&& result.disp_z == $past(result.disp_z))
		else $error("burst result missing or not equal to previous");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

	// config writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind imu_gravity_removal_moving_average_core igr_checker u_igr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire
